// ----- sv/ctd_pkg.sv -----
// ctd_pkg: shared types and constants of the chunked transfer deframer.
// Character classes, parse modes, error causes and the result word.
// No dependencies.
package ctd_pkg;

  localparam int DEF_SIZE_DIGITS     = 16;
  localparam int DEF_SIGNATURE_CHARS = 64;
  localparam int DEF_LINE_LIMIT      = 4096;

  localparam int LINE_W   = 13;   // line length and max_line_length width
  localparam int SIG_W    = 7;    // saturating signature length counter
  localparam int KEY_LEN  = 16;
  localparam int KEY_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_CHUNKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_ALLOWED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_LENGTH = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;

  localparam logic [7:0] SIG_KEY [KEY_LEN] = '{
    8'h63, 8'h68, 8'h75, 8'h6E, 8'h6B, 8'h2D, 8'h73, 8'h69,
    8'h67, 8'h6E, 8'h61, 8'h74, 8'h75, 8'h72, 8'h65, 8'h3D
  };

  typedef enum logic [2:0] {
    MODE_HEADER, MODE_TRAILER, MODE_DATA, MODE_DATAEND, MODE_DONE, MODE_FAILED
  } mode_t;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_LINE_LONG    = 4'd1,
    ERR_NO_CRLF      = 4'd2,
    ERR_BAD_SIZE     = 4'd3,
    ERR_NO_SIG       = 4'd4,
    ERR_DATA_CRLF    = 4'd5,
    ERR_TRAILER      = 4'd6,
    ERR_BAD_TRAILER  = 4'd7,
    ERR_AFTER_END    = 4'd8
  } cause_t;

  typedef struct packed {
    logic [7:0] code;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_semi;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_t;

  localparam char_t CR_CLASS = '{code: CHAR_CR, is_cr: 1'b1, is_lf: 1'b0,
                                 is_colon: 1'b0, is_semi: 1'b0, is_hex: 1'b0,
                                 hex_val: 4'd0};

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_last_byte;
    logic       header_accepted;
    logic       final_chunk;
    logic       stream_done;
    logic       error_flag;
    cause_t     error_cause;
  } result_t;

  typedef struct packed {
    logic       signed_chunks;
    logic       trailer_allowed;
    logic [LINE_W-1:0] max_line_length;
  } cfg_t;

endpackage

// ----- sv/ctd_fifo.sv -----
// ctd_fifo: small first-in first-out queue of words.
// Generic over width and depth; no package dependencies.
module ctd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end
endmodule

// ----- sv/ctd_front.sv -----
// ctd_front: accepts body words and classifies each character.
// Depends on ctd_pkg and ctd_fifo.
module ctd_front import ctd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] byte_in,
  output logic       full,
  input  logic       take,
  output char_t      ch,
  output logic       ch_empty
);
  char_t cls;

  // classify: hex value, line terminators and separators
  always_comb begin
    cls          = '0;
    cls.code     = byte_in;
    cls.is_cr    = (byte_in == CHAR_CR);
    cls.is_lf    = (byte_in == CHAR_LF);
    cls.is_colon = (byte_in == CHAR_COLON);
    cls.is_semi  = (byte_in == CHAR_SEMI);
    if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(byte_in - 8'h30);
    end else if (byte_in >= 8'h61 && byte_in <= 8'h66) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(byte_in - 8'h57);
    end else if (byte_in >= 8'h41 && byte_in <= 8'h46) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(byte_in - 8'h37);
    end
  end

  ctd_fifo #(.WIDTH($bits(char_t)), .DEPTH(2)) u_queue (
    .clk(clk), .rst(rst),
    .wr_en(push), .wr_data(cls), .full(full),
    .rd_en(take), .rd_data(ch), .empty(ch_empty)
  );
endmodule

// ----- sv/ctd_back.sv -----
// ctd_back: line parser and payload pass-through, feeding the result queue.
// Depends on ctd_pkg and ctd_fifo.
module ctd_back import ctd_pkg::*; #(
  parameter int SIZE_DIGITS     = DEF_SIZE_DIGITS,
  parameter int SIGNATURE_CHARS = DEF_SIGNATURE_CHARS,
  parameter int LINE_LIMIT      = DEF_LINE_LIMIT
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  char_t   ch,
  input  logic    ch_empty,
  output logic    take,
  input  logic    pop,
  output result_t res_out,
  output logic    empty
);
  localparam int ACC_W = 4 * SIZE_DIGITS;
  localparam int CNT_W = $clog2(SIZE_DIGITS + 2);

  typedef struct packed {
    logic [LINE_W-1:0] len;
    logic [CNT_W-1:0]  cnt;
    logic [ACC_W-1:0]  acc;
    logic              in_ext;
    logic [KEY_W-1:0]  key_idx;
    logic              key_miss;
    logic [SIG_W-1:0]  sig_len;
    logic              pend_cr;
    logic              colon;
    logic              dig_err;
  } line_t;

  function automatic line_t line_char(line_t s, char_t c, logic trl);
    line_t r;
    r = s;
    if (trl) begin
      if (c.is_colon) r.colon = 1'b1;
    end else if (!s.in_ext) begin
      if (c.is_semi) begin
        r.in_ext = 1'b1;
      end else begin
        if (s.cnt <= CNT_W'(SIZE_DIGITS)) r.cnt = s.cnt + 1'b1;
        if (!c.is_hex) begin
          r.dig_err = 1'b1;
        end else if (r.cnt <= CNT_W'(SIZE_DIGITS)) begin
          r.acc = (s.acc << 4) | ACC_W'(c.hex_val);
        end
      end
    end else if (s.key_idx < KEY_W'(KEY_LEN)) begin
      if (c.code != SIG_KEY[s.key_idx[3:0]]) r.key_miss = 1'b1;
      r.key_idx = s.key_idx + 1'b1;
    end else if (s.sig_len != {SIG_W{1'b1}}) begin
      r.sig_len = s.sig_len + 1'b1;
    end
    return r;
  endfunction

  mode_t             mode, mode_next;
  line_t             ln, ln_next, ln_tmp;
  logic [ACC_W-1:0]  remain, remain_next;
  logic              crlf, crlf_next;
  cause_t            err, err_next;
  logic [LINE_W-1:0] limit;
  logic              res_full, matched, trl;
  result_t           res;

  assign take  = !ch_empty && !res_full;
  assign limit = (cfg.max_line_length < LINE_W'(LINE_LIMIT)) ?
                 cfg.max_line_length : LINE_W'(LINE_LIMIT);
  assign trl   = (mode == MODE_TRAILER);
  assign matched = (ln.key_idx == KEY_W'(KEY_LEN)) && !ln.key_miss;

  always_comb begin
    mode_next   = mode;
    ln_next     = ln;
    ln_tmp      = ln;
    remain_next = remain;
    crlf_next   = crlf;
    err_next    = err;
    res         = '0;
    case (mode)
      MODE_HEADER, MODE_TRAILER: begin
        if (!ch.is_lf) begin
          if (ln.len >= limit) begin
            err_next  = ERR_LINE_LONG;
            mode_next = MODE_FAILED;
          end else begin
            // a held CR that was not followed by LF is a plain line character
            if (ln.pend_cr) ln_tmp = line_char(ln_tmp, CR_CLASS, trl);
            ln_tmp.pend_cr = ch.is_cr;
            if (!ch.is_cr) ln_tmp = line_char(ln_tmp, ch, trl);
            ln_tmp.len = ln.len + 1'b1;
            ln_next = ln_tmp;
          end
        end else if (!ln.pend_cr) begin
          err_next  = ERR_NO_CRLF;
          mode_next = MODE_FAILED;
        end else if (!trl) begin
          if (ln.cnt == '0 || ln.cnt > CNT_W'(SIZE_DIGITS) || ln.dig_err) begin
            err_next  = ERR_BAD_SIZE;
            mode_next = MODE_FAILED;
          end else if (cfg.signed_chunks &&
                       !(matched && ln.sig_len == SIG_W'(SIGNATURE_CHARS))) begin
            err_next  = ERR_NO_SIG;
            mode_next = MODE_FAILED;
          end else begin
            res.header_accepted = 1'b1;
            if (ln.acc == '0) begin
              res.final_chunk = 1'b1;
              mode_next       = MODE_TRAILER;
            end else begin
              remain_next = ln.acc;
              mode_next   = MODE_DATA;
            end
            ln_next = '0;
          end
        end else begin
          if (ln.len == LINE_W'(1)) begin
            mode_next = MODE_DONE;
            ln_next   = '0;
          end else if (!cfg.trailer_allowed) begin
            err_next  = ERR_TRAILER;
            mode_next = MODE_FAILED;
          end else if (!ln.colon) begin
            err_next  = ERR_BAD_TRAILER;
            mode_next = MODE_FAILED;
          end else begin
            ln_next = '0;
          end
        end
      end
      MODE_DATA: begin
        res.payload_byte  = ch.code;
        res.payload_valid = 1'b1;
        remain_next       = remain - 1'b1;
        if (remain == ACC_W'(1)) begin
          res.chunk_last_byte = 1'b1;
          mode_next           = MODE_DATAEND;
          crlf_next           = 1'b0;
        end
      end
      MODE_DATAEND: begin
        if (crlf ? !ch.is_lf : !ch.is_cr) begin
          err_next  = ERR_DATA_CRLF;
          mode_next = MODE_FAILED;
        end else if (crlf) begin
          crlf_next = 1'b0;
          mode_next = MODE_HEADER;
          ln_next   = '0;
        end else begin
          crlf_next = 1'b1;
        end
      end
      MODE_DONE: begin
        if (!ch.is_cr && !ch.is_lf) begin
          err_next  = ERR_AFTER_END;
          mode_next = MODE_FAILED;
        end
      end
      default: begin
        // in failed mode each word is still taken and yields a result word with the error set
      end
    endcase
    res.stream_done = (mode_next == MODE_DONE);
    res.error_flag  = (err_next != ERR_NONE);
    res.error_cause = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_HEADER;
      ln     <= '0;
      remain <= '0;
      crlf   <= 1'b0;
      err    <= ERR_NONE;
    end else if (take) begin
      mode   <= mode_next;
      ln     <= ln_next;
      remain <= remain_next;
      crlf   <= crlf_next;
      err    <= err_next;
    end
  end

  ctd_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_results (
    .clk(clk), .rst(rst),
    .wr_en(take), .wr_data(res), .full(res_full),
    .rd_en(pop), .rd_data(res_out), .empty(empty)
  );
endmodule

// ----- sv/chunked_transfer_deframer_unit.sv -----
// chunked_transfer_deframer_unit: top level of the chunked body deframer.
// Depends on ctd_pkg, ctd_front, ctd_back and ctd_fifo.
//
//  channel   | direction | handshake               | carries
//  ----------+-----------+-------------------------+-------------------------------
//  input     | in        | push / full             | byte_in
//  result    | out       | pop / empty             | payload and status fields
//  config    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One word enters per cycle and one result word leaves per cycle when both
// sides keep moving; a word accepted at one edge is classified into the input
// queue, then parsed into the result queue, from which its result word is popped.
// The parse step (one character class plus one line state update) sets that rate.
// Reset (rst, synchronous) empties both queues, clears the parser to header mode
// and loads the default configuration.
// Input and result queues stall independently; a full result queue holds the parser.
module chunked_transfer_deframer_unit import ctd_pkg::*; #(
  parameter int SIZE_DIGITS     = DEF_SIZE_DIGITS,
  parameter int SIGNATURE_CHARS = DEF_SIGNATURE_CHARS,
  parameter int LINE_LIMIT      = DEF_LINE_LIMIT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           byte_in,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           payload_byte,
  output logic                 payload_valid,
  output logic                 chunk_last_byte,
  output logic                 header_accepted,
  output logic                 final_chunk,
  output logic                 stream_done,
  output logic                 error_flag,
  output logic [3:0]           error_cause,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LINE_W-1:0]    cfg_data
);
  cfg_t    cfg;
  char_t   ch;
  logic    ch_empty, take;
  result_t res;

  // Configuration is always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signed_chunks   <= 1'b0;
      cfg.trailer_allowed <= 1'b0;
      cfg.max_line_length <= LINE_W'(LINE_LIMIT);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIGNED_CHUNKS:   cfg.signed_chunks   <= cfg_data[0];
        REG_TRAILER_ALLOWED: cfg.trailer_allowed <= cfg_data[0];
        REG_MAX_LINE_LENGTH: cfg.max_line_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: take the word and classify it.
  ctd_front u_front (
    .clk(clk), .rst(rst),
    .push(push), .byte_in(byte_in), .full(full),
    .take(take), .ch(ch), .ch_empty(ch_empty)
  );

  // Back: advance the parser and queue the result word.
  ctd_back #(
    .SIZE_DIGITS(SIZE_DIGITS),
    .SIGNATURE_CHARS(SIGNATURE_CHARS),
    .LINE_LIMIT(LINE_LIMIT)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .ch(ch), .ch_empty(ch_empty), .take(take),
    .pop(pop), .res_out(res), .empty(empty)
  );

  assign payload_byte    = res.payload_byte;
  assign payload_valid   = res.payload_valid;
  assign chunk_last_byte = res.chunk_last_byte;
  assign header_accepted = res.header_accepted;
  assign final_chunk     = res.final_chunk;
  assign stream_done     = res.stream_done;
  assign error_flag      = res.error_flag;
  assign error_cause     = res.error_cause;
endmodule

// ----- sv/ctd_checker.sv -----
// ctd_checker: port-level checks of the deframer's result words.
// Depends on ctd_pkg; bound to chunked_transfer_deframer_unit.
module ctd_checker import ctd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] payload_byte,
  input logic       payload_valid,
  input logic       chunk_last_byte,
  input logic       header_accepted,
  input logic       final_chunk,
  input logic       stream_done,
  input logic       error_flag,
  input logic [3:0] error_cause
);
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && error_flag) |=> (empty || error_flag))
    else $error("error flag dropped after being set");

  a_err_cause: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (error_flag == (error_cause != ERR_NONE)))
    else $error("error flag and cause disagree");

  a_no_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && !payload_valid) |-> (payload_byte == 8'd0 && !chunk_last_byte))
    else $error("payload fields set on a non-payload word");

  a_final_hdr: assert property (@(posedge clk) disable iff (rst)
    (!empty && final_chunk) |-> (header_accepted && !payload_valid))
    else $error("final chunk without an accepted header");

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && stream_done) |-> !error_flag)
    else $error("stream done together with an error");
endmodule

bind chunked_transfer_deframer_unit ctd_checker u_ctd_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop),
  .payload_byte(payload_byte), .payload_valid(payload_valid),
  .chunk_last_byte(chunk_last_byte), .header_accepted(header_accepted),
  .final_chunk(final_chunk), .stream_done(stream_done),
  .error_flag(error_flag), .error_cause(error_cause)
);

// ----- test/chunked_transfer_deframer_unit_tb.sv -----
// testbench: self-checking bench for chunked_transfer_deframer_unit.
// Feeds chunked bodies byte by byte and checks every result word against a local parser.
// Depends on ctd_pkg and chunked_transfer_deframer_unit.
module testbench;
  import ctd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] byte_in = 8'd0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] payload_byte;
  logic payload_valid, chunk_last_byte, header_accepted, final_chunk;
  logic stream_done, error_flag;
  logic [3:0] error_cause;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SIGNED_CHUNKS;
  logic [LINE_W-1:0] cfg_data = '0;

  chunked_transfer_deframer_unit dut (.*);

  // clock: 10 high, 10 low
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Parser state kept by the bench: configuration and per-line tracking.
  // ---------------------------------------------------------------------
  logic              want_sig, trailers_ok;
  logic [LINE_W-1:0] line_cap;
  mode_t             pmode;
  int                line_len, digits, key_idx, sig_len;
  logic [63:0]       size_acc, left_in_chunk;
  logic              in_ext, key_bad, cr_held, saw_cr, has_colon, dig_err;
  cause_t            err;

  byte unsigned      body_q[$];     // bytes waiting to be pushed
  result_t           expect_q[$];   // predicted result words, oldest first
  int                fails = 0;
  int                cycles = 0;
  bit                no_gaps = 1'b0; // stretch with no idling on either side

  function void clear_line();
    line_len = 0; digits = 0; size_acc = '0; in_ext = 0; key_idx = 0;
    key_bad = 0; sig_len = 0; cr_held = 0; has_colon = 0; dig_err = 0;
  endfunction

  function void reset_parser();
    want_sig = 0; trailers_ok = 0; line_cap = LINE_W'(DEF_LINE_LIMIT);
    pmode = MODE_HEADER; left_in_chunk = '0; saw_cr = 0; err = ERR_NONE;
    clear_line();
  endfunction

  function int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // one character of a header or trailer line (LF and line-ending CR excluded)
  function void take_char(logic [7:0] c);
    int v;
    if (pmode == MODE_TRAILER) begin
      if (c == CHAR_COLON) has_colon = 1;
      return;
    end
    if (!in_ext) begin
      if (c == CHAR_SEMI) begin
        in_ext = 1;
        return;
      end
      v = hex_of(c);
      if (digits <= DEF_SIZE_DIGITS) digits++;
      if (v < 0) dig_err = 1;
      else if (digits <= DEF_SIZE_DIGITS) size_acc = {size_acc[59:0], v[3:0]};
    end else if (key_idx < KEY_LEN) begin
      if (c != SIG_KEY[key_idx]) key_bad = 1;
      key_idx++;
    end else if (sig_len < 127) begin
      sig_len++;
    end
  endfunction

  function void fail_with(cause_t c);
    err = c;
    pmode = MODE_FAILED;
  endfunction

  // advance the parser by one body byte and return the result word it yields
  function result_t parse_byte(logic [7:0] c);
    result_t r;
    int cap;
    r = '0;
    r.error_cause = ERR_NONE;
    case (pmode)
      MODE_HEADER, MODE_TRAILER: begin
        cap = (line_cap < DEF_LINE_LIMIT) ? line_cap : DEF_LINE_LIMIT;
        if (c != CHAR_LF) begin
          if (line_len + 1 > cap) fail_with(ERR_LINE_LONG);
          else begin
            if (cr_held) take_char(CHAR_CR);
            cr_held = (c == CHAR_CR);
            if (!cr_held) take_char(c);
            line_len++;
          end
        end else if (!cr_held) begin
          fail_with(ERR_NO_CRLF);
        end else if (pmode == MODE_HEADER) begin
          if (digits == 0 || digits > DEF_SIZE_DIGITS || dig_err)
            fail_with(ERR_BAD_SIZE);
          else if (want_sig && !(key_idx == KEY_LEN && !key_bad &&
                                 sig_len == DEF_SIGNATURE_CHARS))
            fail_with(ERR_NO_SIG);
          else begin
            r.header_accepted = 1;
            if (size_acc == 0) begin
              r.final_chunk = 1;
              pmode = MODE_TRAILER;
            end else begin
              left_in_chunk = size_acc;
              pmode = MODE_DATA;
            end
            clear_line();
          end
        end else begin
          if (line_len == 1) begin
            pmode = MODE_DONE;
            clear_line();
          end else if (!trailers_ok) fail_with(ERR_TRAILER);
          else if (!has_colon) fail_with(ERR_BAD_TRAILER);
          else clear_line();
        end
      end
      MODE_DATA: begin
        r.payload_byte = c;
        r.payload_valid = 1;
        left_in_chunk--;
        if (left_in_chunk == 0) begin
          r.chunk_last_byte = 1;
          pmode = MODE_DATAEND;
          saw_cr = 0;
        end
      end
      MODE_DATAEND: begin
        if (c != (saw_cr ? CHAR_LF : CHAR_CR)) fail_with(ERR_DATA_CRLF);
        else if (saw_cr) begin
          saw_cr = 0;
          pmode = MODE_HEADER;
          clear_line();
        end else saw_cr = 1;
      end
      MODE_DONE: if (c != CHAR_CR && c != CHAR_LF) fail_with(ERR_AFTER_END);
      default: ;
    endcase
    r.stream_done = (pmode == MODE_DONE);
    r.error_flag = (err != ERR_NONE);
    r.error_cause = err;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer the next queued byte at the falling edge, idle at random.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    push <= !rst && body_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 37);
    byte_in <= body_q.size() > 0 ? body_q[0] : 8'($urandom);
  end

  // on acceptance, drop the byte from the queue and predict its word
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      expect_q.push_back(parse_byte(byte_in));
      void'(body_q.pop_front());
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stall at random, compare each accepted word field by field.
  // ---------------------------------------------------------------------
  always @(negedge clk)
    pop <= !rst && (no_gaps || $urandom_range(0, 99) >= 37);

  function void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0h got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    result_t w;
    if (!rst && pop && !empty) begin
      if (expect_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        w = expect_q.pop_front();
        check_field("payload_byte", w.payload_byte, payload_byte);
        check_field("payload_valid", w.payload_valid, payload_valid);
        check_field("chunk_last_byte", w.chunk_last_byte, chunk_last_byte);
        check_field("header_accepted", w.header_accepted, header_accepted);
        check_field("final_chunk", w.final_chunk, final_chunk);
        check_field("stream_done", w.stream_done, stream_done);
        check_field("error_flag", w.error_flag, error_flag);
        check_field("error_cause", int'(w.error_cause), int'(error_cause));
      end
    end
  end

  // hard stop for a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("chunked_transfer_deframer_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_str(string s);
    foreach (s[i]) body_q.push_back(s[i]);
  endtask

  function automatic byte unsigned not_lf();
    byte unsigned c;
    do c = 8'($urandom); while (c == CHAR_LF);
    return c;
  endfunction

  // hold until every queued byte went in and every word came out
  task automatic drain();
    while (body_q.size() != 0 || expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= LINE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SIGNED_CHUNKS:   want_sig = value[0];
      REG_TRAILER_ALLOWED: trailers_ok = value[0];
      default:             line_cap = LINE_W'(value);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // header line for a chunk of the given size, fitted to the current line cap
  task automatic add_header(int size);
    byte unsigned hex[$];
    int cap, pad, room, ext;
    string key;
    key = "chunk-signature=";
    cap = (line_cap < DEF_LINE_LIMIT) ? line_cap : DEF_LINE_LIMIT;
    do begin
      hex.push_front(8'((size % 16) < 10 ? "0" + size % 16 :
                     ($urandom_range(0, 1) ? "a" : "A") + size % 16 - 10));
      size /= 16;
    end while (size > 0);
    pad = $urandom_range(0, DEF_SIZE_DIGITS - hex.size());
    if (!want_sig && pad + hex.size() + 1 > cap) pad = 0;
    repeat (pad) hex.push_front("0");
    foreach (hex[i]) body_q.push_back(hex[i]);
    if (want_sig) begin
      add_str({";", key});
      repeat (DEF_SIGNATURE_CHARS) body_q.push_back(not_lf());
    end else begin
      room = cap - hex.size() - 2;   // room left after ';' and the CR
      if (room >= 0 && $urandom_range(0, 2) == 0) begin
        ext = (cap <= 200 && $urandom_range(0, 3) == 0) ? room
            : $urandom_range(0, room < 24 ? room : 24);
        body_q.push_back(CHAR_SEMI);
        if (ext >= KEY_LEN && $urandom_range(0, 1)) begin
          add_str(key);
          ext -= KEY_LEN;
        end
        repeat (ext) body_q.push_back(not_lf());
      end
    end
    add_str("\r\n");
  endtask

  task automatic add_chunk(int size);
    add_header(size);
    repeat (size) body_q.push_back(8'($urandom));
    add_str("\r\n");
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int cap, pick, ending;
    reset_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: default registers, payload extremes, empty and repeated extension,
    // a CR inside the line that is not a line end, CR as a payload byte
    write_reg(REG_SIGNED_CHUNKS, 0);
    write_reg(REG_TRAILER_ALLOWED, 0);
    write_reg(REG_MAX_LINE_LENGTH, DEF_LINE_LIMIT);
    add_str("1;\r\n");
    body_q.push_back(8'h00);
    add_str("\r\n3;a;b\rc\r\n");
    body_q.push_back(8'hFF);
    body_q.push_back(CHAR_CR);
    body_q.push_back(8'h80);
    add_str("\r\n");
    drain();

    // random chunk phases under varying configuration; one gap-free phase
    for (int ph = 0; ph < 8; ph++) begin
      no_gaps = (ph == 3);
      write_reg(REG_SIGNED_CHUNKS, (ph == 1) ? 1 : $urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      if (want_sig) cap = (pick == 0) ? 98 : (pick == 1) ? 8191 : $urandom_range(98, 140);
      else cap = (pick == 0) ? 18 : (pick == 1) ? 8191 : $urandom_range(18, 120);
      if (ph == 0) cap = DEF_LINE_LIMIT;
      write_reg(REG_MAX_LINE_LENGTH, cap);
      while (body_q.size() < 110) begin
        pick = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 24);
        add_chunk(pick);
      end
      drain();
    end
    no_gaps = 0;

    // closing phase: a clean end of stream or one malformed construct
    write_reg(REG_SIGNED_CHUNKS, 0);
    write_reg(REG_MAX_LINE_LENGTH, DEF_LINE_LIMIT);
    ending = $urandom_range(0, 8);
    case (ending)
      1: begin
        write_reg(REG_MAX_LINE_LENGTH, $urandom_range(0, 1));
        add_str("5\r\n");
      end
      2: add_str($urandom_range(0, 1) ? "5\n" : "\n");
      3: begin
        pick = $urandom_range(0, 2);
        add_str(pick == 0 ? "g\r\n" : pick == 1 ? ";x\r\n" : "11111111111111111\r\n");
      end
      4: begin
        write_reg(REG_SIGNED_CHUNKS, 1);
        add_str("5;chunk-signature=abc\r\n");
      end
      5: add_str("1\r\nAB");
      6: begin
        write_reg(REG_TRAILER_ALLOWED, 0);
        add_str("0\r\nab:c\r\n");
      end
      7: begin
        write_reg(REG_TRAILER_ALLOWED, 1);
        add_str("0\r\nabc\r\n");
      end
      default: begin
        write_reg(REG_TRAILER_ALLOWED, $urandom_range(0, 1));
        add_str("0\r\n");
        if (trailers_ok) begin
          repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 6)) body_q.push_back(not_lf());
            body_q.push_back(CHAR_COLON);
            repeat ($urandom_range(0, 6)) body_q.push_back(not_lf());
            add_str("\r\n");
          end
        end
        add_str("\r\n\r\n\n\r");
        if (ending == 8) add_str("Z");
      end
    endcase
    // trailing random bytes after the end or the error; each still yields a checked word
    repeat (4) body_q.push_back(8'($urandom));
    drain();
    repeat (10) @(posedge clk);

    if (fails == 0) $display("chunked_transfer_deframer_unit: match");
    else $display("chunked_transfer_deframer_unit: mismatch");
    $finish;
  end

endmodule
